@@ src/fbfl_pkg.sv @@
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared constants, codes and controller/datapath types for the fixed-size
// block pool allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int POOL_PAGES  = 16;
  localparam int PAGE_BLOCKS = 64;
  localparam int LINK_DEPTH  = POOL_PAGES * PAGE_BLOCKS;

  localparam int BLK_W  = $clog2(LINK_DEPTH);      // block handle width
  localparam int HEAD_W = BLK_W + 1;               // handle plus empty mark
  localparam int SLOT_W = $clog2(PAGE_BLOCKS);
  localparam int PAGE_W = $clog2(POOL_PAGES);
  localparam int CNT_W  = $clog2(POOL_PAGES + 1);  // page counts 0..POOL_PAGES
  localparam int BIP_W  = 7;                        // blocks_in_page register
  localparam int LIM_W  = 5;                        // page_limit register
  localparam int OP_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_NOP     = 2'd3
  } fbfl_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCKS_IN_PAGE = 1'd0,
    CFG_PAGE_LIMIT     = 1'd1
  } fbfl_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD,
    ST_POP,
    ST_DONE
  } fbfl_state_t;

  typedef struct packed {
    logic cap;        // capture operation and page count of an accepted request
    logic rd_en;      // read the link of the list head
    logic push_free;  // push the freed block onto the list
    logic fill_wr;    // push one slot of the page being added
    logic pop;        // head takes the link read back
    logic load_out;   // load the result register
    logic out_exh;    // result reports an exhausted pool
    logic out_grant;  // result carries the popped head
  } fbfl_cmd_t;

  typedef struct packed {
    logic head_empty;
    logic at_limit;
    logic at_limit_next;
    logic last_slot;
    logic remain_one;
    logic count_zero;
    logic op_alloc;
    logic out_free;
  } fbfl_sts_t;

endpackage

@@ src/fbfl_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Sequencer for the allocator: decodes each request and steps the datapath
// through pops, pushes and page fills.
// ----------------------------------------------------------------------------
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [OP_W-1:0]     in_operation,
  input  logic                in_is_null,
  output logic                in_stall,
  input  fbfl_sts_t           sts,
  output fbfl_cmd_t           cmd
);

  fbfl_state_t state_r, state_nxt;
  logic        accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (fbfl_op_t'(in_operation))
            OP_ALLOC: begin
              if (!sts.head_empty)    state_nxt = ST_POP;
              else if (!sts.at_limit) state_nxt = ST_FILL;
              else                    state_nxt = ST_DONE;
            end
            OP_RESERVE: begin
              if (!sts.count_zero && !sts.at_limit) state_nxt = ST_FILL;
              else                                  state_nxt = ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        if (sts.last_slot) begin
          if (sts.op_alloc)                               state_nxt = ST_RD;
          else if (sts.remain_one || sts.at_limit_next)   state_nxt = ST_DONE;
          else                                            state_nxt = ST_FILL;
        end
      end
      ST_RD:   state_nxt = ST_POP;
      ST_POP:  if (sts.out_free) state_nxt = ST_IDLE;
      ST_DONE: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.cap = 1'b1;
          // An allocate from a non-empty list starts its link read right away.
          if (fbfl_op_t'(in_operation) == OP_ALLOC && !sts.head_empty) begin
            cmd.rd_en = 1'b1;
          end
          if (fbfl_op_t'(in_operation) == OP_FREE && !in_is_null) begin
            cmd.push_free = 1'b1;
          end
        end
      end
      ST_FILL: cmd.fill_wr = 1'b1;
      ST_RD:   cmd.rd_en   = 1'b1;
      ST_POP: begin
        if (sts.out_free) begin
          cmd.pop       = 1'b1;
          cmd.load_out  = 1'b1;
          cmd.out_grant = 1'b1;
        end
      end
      ST_DONE: begin
        // An allocate only ends here when the pool is exhausted.
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_exh  = sts.op_alloc;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ src/fbfl_dp.sv @@
// ----------------------------------------------------------------------------
// fbfl_dp
// Datapath: configuration, list head, page counter, next-link memory and
// the result register.
// ----------------------------------------------------------------------------
module fbfl_dp
  import fbfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [BLK_W-1:0]      in_block_index,
  input  logic [CNT_W-1:0]      in_page_count,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  out_status,
  output logic [BLK_W-1:0]      out_granted_block,
  output logic [CNT_W-1:0]      out_pages_in_use,
  input  fbfl_cmd_t             cmd,
  output fbfl_sts_t             sts
);

  logic [BIP_W-1:0]  bip_r;
  logic [LIM_W-1:0]  lim_r;
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  pages_r, pages_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic [OP_W-1:0]   op_r;
  logic [HEAD_W-1:0] rdata_r;

  logic              out_valid_r;
  logic              out_status_r;
  logic [BLK_W-1:0]  out_granted_r;
  logic [CNT_W-1:0]  out_pages_r;

  logic [HEAD_W-1:0] link_mem [LINK_DEPTH];

  logic [BIP_W-1:0]  n_eff;
  logic [CNT_W-1:0]  lim_eff;
  logic [BLK_W-1:0]  fill_addr;
  logic [HEAD_W-1:0] fill_link;
  logic              wr_en;
  logic [BLK_W-1:0]  wr_addr;
  logic [HEAD_W-1:0] wr_data;

  // Out-of-range settings saturate: zero blocks acts as one, zero limit as max.
  always_comb begin
    if (bip_r == '0)                             n_eff = BIP_W'(1);
    else if (bip_r > BIP_W'(PAGE_BLOCKS))        n_eff = BIP_W'(PAGE_BLOCKS);
    else                                         n_eff = bip_r;
    if (lim_r == '0 || lim_r > LIM_W'(POOL_PAGES)) lim_eff = CNT_W'(POOL_PAGES);
    else                                           lim_eff = CNT_W'(lim_r);
  end

  // Slot s of the new page links to slot s-1, and slot 0 to the old head.
  assign fill_addr = {pages_r[PAGE_W-1:0], slot_r};
  assign fill_link = (slot_r == '0) ? head_r
                   : {1'b0, pages_r[PAGE_W-1:0], slot_r - SLOT_W'(1)};

  assign wr_en   = cmd.push_free || cmd.fill_wr;
  assign wr_addr = cmd.push_free ? in_block_index : fill_addr;
  assign wr_data = cmd.push_free ? head_r : fill_link;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= link_mem[head_r[BLK_W-1:0]];
    end
  end

  always_comb begin
    head_nxt   = head_r;
    pages_nxt  = pages_r;
    slot_nxt   = slot_r;
    remain_nxt = remain_r;
    if (cmd.cap) begin
      slot_nxt   = '0;
      remain_nxt = in_page_count;
    end
    if (cmd.push_free) begin
      head_nxt = {1'b0, in_block_index};
    end
    if (cmd.fill_wr) begin
      head_nxt = {1'b0, fill_addr};
      if (sts.last_slot) begin
        slot_nxt   = '0;
        pages_nxt  = pages_r + CNT_W'(1);
        remain_nxt = remain_r - CNT_W'(1);
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
    if (cmd.pop) begin
      head_nxt = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bip_r       <= BIP_W'(PAGE_BLOCKS);
      lim_r       <= '0;
      head_r      <= HEAD_W'(LINK_DEPTH);
      pages_r     <= '0;
      slot_r      <= '0;
      remain_r    <= '0;
      op_r        <= OP_NOP;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (fbfl_cfg_t'(cfg_index))
          CFG_BLOCKS_IN_PAGE: bip_r <= cfg_data[BIP_W-1:0];
          CFG_PAGE_LIMIT:     lim_r <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      head_r   <= head_nxt;
      pages_r  <= pages_nxt;
      slot_r   <= slot_nxt;
      remain_r <= remain_nxt;
      if (cmd.cap) begin
        op_r <= in_operation;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= cmd.out_exh;
      out_granted_r <= cmd.out_grant ? head_r[BLK_W-1:0] : '0;
      out_pages_r   <= pages_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_granted_r;
  assign out_pages_in_use  = out_pages_r;

  assign sts.head_empty    = head_r[BLK_W];
  assign sts.at_limit      = (pages_r >= lim_eff);
  assign sts.at_limit_next = ((pages_r + CNT_W'(1)) >= lim_eff);
  assign sts.last_slot     = ({1'b0, slot_r} == (n_eff - BIP_W'(1)));
  assign sts.remain_one    = (remain_r == CNT_W'(1));
  assign sts.count_zero    = (in_page_count == '0);
  assign sts.op_alloc      = (fbfl_op_t'(op_r) == OP_ALLOC);
  assign sts.out_free      = !out_valid_r || !out_stall;

endmodule

@@ src/fixed_block_free_list_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit
// Fixed-size block pool with a LIFO free list of next links.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_* with valid/stall: allocate, free or reserve.
//   Each request yields exactly one response on out_*: status (1 means the
//   pool is exhausted), the granted block handle and the page count.
//   The cfg_* port writes blocks_in_page (index 0) and page_limit (index 1);
//   write it only while no request is outstanding.
// Timing:
//   One request is worked on at a time. A free, a reserve of no pages or an
//   exhausted allocate goes straight to its response; an allocate from a
//   non-empty list pops the head once the registered read of the link
//   memory returns. Adding a page writes one link per cycle, one for each
//   of the saturated blocks_in_page (1 to 64) slots; an allocate that adds a
//   page then reads and pops the new head, and a reserve adds pages until its count or the page limit is reached.
// Reset:
//   rst_n clears the list to empty and the page count to zero. The link
//   memory is not cleared; only entries already pushed are ever read.
// Stall:
//   The response is held in an output register while out_stall is high; a
//   new request is taken meanwhile, and its response waits for the slot.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit
  import fbfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [BLK_W-1:0]      in_block_index,
  input  logic                  in_is_null,
  input  logic [CNT_W-1:0]      in_page_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_status,
  output logic [BLK_W-1:0]      out_granted_block,
  output logic [CNT_W-1:0]      out_pages_in_use
);

  fbfl_cmd_t cmd;
  fbfl_sts_t sts;

  fbfl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_is_null   (in_is_null),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  fbfl_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_operation      (in_operation),
    .in_block_index    (in_block_index),
    .in_page_count     (in_page_count),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .out_pages_in_use  (out_pages_in_use),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

@@ src/fbfl_chk.sv @@
// ----------------------------------------------------------------------------
// fbfl_chk
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbfl_chk
  import fbfl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_wr_en,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [OP_W-1:0]       in_operation,
  input logic [BLK_W-1:0]      in_block_index,
  input logic                  in_is_null,
  input logic [CNT_W-1:0]      in_page_count,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_status,
  input logic [BLK_W-1:0]      out_granted_block,
  input logic [CNT_W-1:0]      out_pages_in_use
);

  // A stalled response stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("response dropped while stalled");

  // An exhausted allocate never hands out a block.
  a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_granted_block == '0)
    else $error("exhausted response carries a block");

  // The page count never exceeds the build maximum.
  a_pages_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pages_in_use <= CNT_W'(POOL_PAGES))
    else $error("page count beyond maximum");

  // The block is ready for a request right after reset.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("not idle after reset");

endmodule

bind fixed_block_free_list_allocator_unit fbfl_chk u_fbfl_chk (.*);
